[hw/rtl/ags_pkg.sv]
// ============================================================================
// ags_pkg: shared types and constants of the vector argsort core
// Word layouts of both channels, the cell entry, the chain control group,
// the register map and the controller states.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ags_pkg;

    localparam int MAX_LEN   = 64;
    localparam int KEY_W     = 32;
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int SRC_POS_W = 6;
    localparam int ADDR_W    = 2;
    localparam int DATA_W    = 32;

    localparam logic [ADDR_W-1:0] REG_ASCENDING_ORDER = ADDR_W'(0);

    typedef struct packed {
        logic signed [KEY_W-1:0] key_value;
        logic                    is_last;
    } in_word_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic [SRC_POS_W-1:0]    source_position;
        logic                    final_result;
        logic                    overflow_flag;
    } out_word_t;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        pos;
    } ent_t;

    typedef struct packed {
        logic insert;
        logic shift_dn;
        logic shift_up;
    } ctrl_t;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

    localparam ent_t EMPTY_ENT = '{valid: 1'b0, key: '0, pos: '0};

endpackage

`default_nettype wire

[hw/rtl/ags_cell.sv]
// ============================================================================
// ags_cell: one slot of the insertion chain
// Holds one key with its arrival position; takes the new key, its lower
// neighbor's entry or its upper neighbor's entry as the chain control says.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ags_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ags_pkg::ctrl_t ctrl,
    input  wire ags_pkg::ent_t  new_ent,
    input  wire ags_pkg::ent_t  lo_ent,
    input  wire ags_pkg::ent_t  hi_ent,
    input  wire logic          lo_ins,
    output ags_pkg::ent_t       ent,
    output logic               ins
);
    import ags_pkg::*;

    logic                    valid_reg, valid_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    ent_t                    sel;

    assign ent = '{valid: valid_reg, key: key_reg, pos: pos_reg};

    // A stable ascending chain: the new key goes after every key not above it.
    assign ins = !valid_reg || ($signed(key_reg) > $signed(new_ent.key));

    always_comb
    begin
        sel = ent;
        if (ctrl.insert)
        begin
            if (ins && lo_ins)
                sel = lo_ent;
            else if (ins)
                sel = new_ent;
        end
        else if (ctrl.shift_dn)
            sel = hi_ent;
        else if (ctrl.shift_up)
            sel = lo_ent;
        valid_next = sel.valid;
        key_next   = sel.key;
        pos_next   = sel.pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

[hw/rtl/vector_argsort_core.sv]
// ============================================================================
// vector_argsort_core: argsort of one vector with its index map
// Keys enter a chain of cells that keeps them in stable ascending order; on
// the closing word the chain shifts its contents out in the chosen order.
// ============================================================================
// Fill: one key word per cycle outside the drain, each inserted into the
// chain at once; keys beyond MAX_LEN only set the overflow flag. Drain:
// the closing word starts it, then one result per cycle unless the result
// channel stalls; descending order first gives no result while the chain
// shifts its contents toward the top cell. The key channel stalls in the
// drain. Reset empties the chain at once and sets ascending order.
`timescale 1ns / 1ps
`default_nettype none

module vector_argsort_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ags_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ags_pkg::DATA_W-1:0]   pwdata,
    output logic [ags_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  wire logic                         key_valid,
    output logic                              key_stall,
    input  wire ags_pkg::in_word_t            key_word,
    output logic                              res_valid,
    input  wire logic                         res_stall,
    output ags_pkg::out_word_t                res_word
);
    import ags_pkg::*;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic            ovf_reg, ovf_next;
    logic            drain_ovf_reg, drain_ovf_next;
    logic            dir_reg, dir_next;
    logic            asc_reg;
    logic            res_valid_reg, res_valid_next;
    out_word_t       res_word_reg, res_word_next;

    ctrl_t           ctrl;
    ent_t            new_ent;
    ent_t            cell_ent [MAX_LEN];
    logic            cell_ins [MAX_LEN];
    ent_t            cand;
    logic            take_in, advance;

    assign pready    = 1'b1;
    assign prdata    = DATA_W'(asc_reg);
    assign key_stall = (state_reg == ST_DRAIN);
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;
    assign take_in   = key_valid && !key_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            asc_reg <= 1'b1;
        else if (psel && penable && pwrite && paddr == REG_ASCENDING_ORDER)
            asc_reg <= pwdata[0];
    end

    assign new_ent = '{valid: 1'b1, key: key_word.key_value, pos: count_reg[IDX_W-1:0]};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEN; gi++)
        begin : g_cell
            ent_t lo_e, hi_e;
            logic lo_i;
            if (gi == 0)
            begin : g_bot
                assign lo_e = EMPTY_ENT;
                assign lo_i = 1'b0;
            end
            else
            begin : g_mid_lo
                assign lo_e = cell_ent[gi-1];
                assign lo_i = cell_ins[gi-1];
            end
            if (gi == MAX_LEN - 1)
            begin : g_top
                assign hi_e = EMPTY_ENT;
            end
            else
            begin : g_mid_hi
                assign hi_e = cell_ent[gi+1];
            end
            ags_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .new_ent (new_ent),
                .lo_ent  (lo_e),
                .hi_ent  (hi_e),
                .lo_ins  (lo_i),
                .ent     (cell_ent[gi]),
                .ins     (cell_ins[gi])
            );
        end
    endgenerate

    assign cand = dir_reg ? cell_ent[0] : cell_ent[MAX_LEN-1];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        ovf_next       = ovf_reg;
        drain_ovf_next = drain_ovf_reg;
        dir_next       = dir_reg;
        res_valid_next = res_valid_reg;
        res_word_next  = res_word_reg;
        ctrl           = '0;
        advance        = 1'b0;

        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_FILL:
            begin
                if (take_in)
                begin
                    if (count_reg < CNT_W'(MAX_LEN))
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    else
                        ovf_next = 1'b1;
                    if (key_word.is_last)
                    begin
                        rem_next       = count_next;
                        drain_ovf_next = ovf_next;
                        dir_next       = asc_reg;
                        count_next     = '0;
                        ovf_next       = 1'b0;
                        state_next     = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                advance = !res_valid_reg || !res_stall;
                if (advance)
                begin
                    ctrl.shift_dn = dir_reg;
                    ctrl.shift_up = !dir_reg;
                    if (cand.valid)
                    begin
                        res_valid_next = 1'b1;
                        res_word_next.sorted_key      = cand.key;
                        res_word_next.source_position = SRC_POS_W'(cand.pos);
                        res_word_next.final_result    = (rem_reg == CNT_W'(1));
                        res_word_next.overflow_flag   = drain_ovf_reg;
                        rem_next = rem_reg - CNT_W'(1);
                        if (rem_reg == CNT_W'(1))
                            state_next = ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            count_reg     <= '0;
            rem_reg       <= '0;
            ovf_reg       <= 1'b0;
            drain_ovf_reg <= 1'b0;
            dir_reg       <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            ovf_reg       <= ovf_next;
            drain_ovf_reg <= drain_ovf_next;
            dir_reg       <= dir_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg <= res_word_next;
    end

endmodule

`default_nettype wire

[hw/rtl/ags_checker.sv]
// ============================================================================
// ags_checker: port-level checks of the vector argsort core
// Watches both channels for the fill and drain sequencing over time.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ags_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               key_valid,
    input wire logic               key_stall,
    input wire ags_pkg::in_word_t  key_word,
    input wire logic               res_valid,
    input wire logic               res_stall,
    input wire ags_pkg::out_word_t res_word
);
    import ags_pkg::*;

    // A closing word always starts a drain, which holds off further keys.
    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall && key_word.is_last |=> key_stall)
        else $error("closing word did not start a drain");

    // The key channel only stalls after a closing word was taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_stall) |-> $past(key_valid && key_word.is_last))
        else $error("key channel stalled without a closing word");

    // The key channel reopens only once the final result word is loaded.
    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(key_stall) |-> res_valid && res_word.final_result)
        else $error("drain ended without a final result word");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("stalled result word changed");

endmodule

bind vector_argsort_core ags_checker u_ags_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_word  (key_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
);

`default_nettype wire
